[sv/dseu_pkg.sv]
package dseu_pkg;

    localparam int XLEN          = 32;
    localparam int REG_COUNT     = 32;
    localparam int RIDX_W        = 5;
    localparam int ACT_W         = 5;
    localparam int MEM_WORDS_DEF = 1024;

    // action codes
    localparam logic [ACT_W-1:0] A_ADD  = 5'd0;
    localparam logic [ACT_W-1:0] A_SUB  = 5'd1;
    localparam logic [ACT_W-1:0] A_AND  = 5'd2;
    localparam logic [ACT_W-1:0] A_OR   = 5'd3;
    localparam logic [ACT_W-1:0] A_XOR  = 5'd4;
    localparam logic [ACT_W-1:0] A_SEQ  = 5'd5;
    localparam logic [ACT_W-1:0] A_SLE  = 5'd6;
    localparam logic [ACT_W-1:0] A_ADDI = 5'd7;
    localparam logic [ACT_W-1:0] A_SUBI = 5'd8;
    localparam logic [ACT_W-1:0] A_ANDI = 5'd9;
    localparam logic [ACT_W-1:0] A_ORI  = 5'd10;
    localparam logic [ACT_W-1:0] A_XORI = 5'd11;
    localparam logic [ACT_W-1:0] A_SEQI = 5'd12;
    localparam logic [ACT_W-1:0] A_SLEI = 5'd13;
    localparam logic [ACT_W-1:0] A_LHI  = 5'd14;
    localparam logic [ACT_W-1:0] A_LW   = 5'd15;
    localparam logic [ACT_W-1:0] A_SW   = 5'd16;
    localparam logic [ACT_W-1:0] A_BEQZ = 5'd17;
    localparam logic [ACT_W-1:0] A_BNEZ = 5'd18;
    localparam logic [ACT_W-1:0] A_JR   = 5'd19;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [RIDX_W-1:0] rd;
        logic [RIDX_W-1:0] rs1;
        logic [RIDX_W-1:0] rs2;
        logic [XLEN-1:0]   imm;
        logic              jflag;
    } t_instr;

    typedef struct packed {
        logic              wr;
        logic [RIDX_W-1:0] rd;
        logic [XLEN-1:0]   val;
        logic              is_ld;
        logic              ld_ok;
        logic              mw;
        logic [XLEN-1:0]   saddr;
        logic [XLEN-1:0]   pc;
    } t_exec;

    typedef struct packed {
        logic [XLEN-1:0]   next_pc;
        logic              reg_written;
        logic [RIDX_W-1:0] written_index;
        logic [XLEN-1:0]   written_value;
        logic              mem_written;
        logic [XLEN-1:0]   store_address;
    } t_result;

endpackage

[sv/dseu_in_if.sv]
interface dseu_in_if;
    logic               valid;
    logic               ready;
    logic [4:0]         action;
    logic [4:0]         dest_index;
    logic [4:0]         src1_index;
    logic [4:0]         src2_index;
    logic signed [31:0] immediate;
    logic               is_jump_or_nop;

    modport source (
        output valid, action, dest_index, src1_index, src2_index, immediate, is_jump_or_nop,
        input  ready
    );
    modport sink (
        input  valid, action, dest_index, src1_index, src2_index, immediate, is_jump_or_nop,
        output ready
    );
endinterface

[sv/dseu_out_if.sv]
interface dseu_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        next_pc;
    logic               reg_written;
    logic [4:0]         written_index;
    logic signed [31:0] written_value;
    logic               mem_written;
    logic [31:0]        store_address;

    modport source (
        output valid, next_pc, reg_written, written_index, written_value, mem_written,
               store_address,
        input  ready
    );
    modport sink (
        input  valid, next_pc, reg_written, written_index, written_value, mem_written,
               store_address,
        output ready
    );
endinterface

[sv/dlx_subset_execute_unit.sv]
// channel    dir  interface    payload
// i_instr    in   dseu_in_if   action, dest/src1/src2 index, immediate, is_jump_or_nop
// o_result   out  dseu_out_if  next_pc, register write, memory store
//
// one item per cycle sustained while the pipe is not held; a result reaches the output queue
// after its item passes the register file read, execute + data memory access and load return
// after reset the data memory is swept to zero, one word a cycle through all MEM_WORDS words,
// with i_instr.ready low during the sweep
// the register file uses per-entry valid bits instead of a sweep
// a two-entry output queue lets the pipe keep taking items while a result waits;
// the whole pipe holds only when the queue is full and not draining
module dlx_subset_execute_unit
    import dseu_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dseu_in_if.sink    i_instr,
    dseu_out_if.source o_result
);

    localparam int MAW = $clog2(MEM_WORDS);

    // operand pick: newest pending write first, then the register file, zero for an entry never written
    function automatic logic [XLEN-1:0] fwd(
        input logic [RIDX_W-1:0] idx,
        input logic [XLEN-1:0]   ram_d,
        input logic              ram_v,
        input logic              s2_en,
        input logic [RIDX_W-1:0] s2_rd,
        input logic [XLEN-1:0]   s2_d,
        input logic              wb_en,
        input logic [RIDX_W-1:0] wb_rd,
        input logic [XLEN-1:0]   wb_d
    );
        logic [XLEN-1:0] res;
        if (s2_en && s2_rd == idx) begin
            res = s2_d;
        end else if (wb_en && wb_rd == idx) begin
            res = wb_d;
        end else if (ram_v) begin
            res = ram_d;
        end else begin
            res = '0;
        end
        return res;
    endfunction

    // control state
    logic                 r_clr;
    logic [MAW-1:0]       r_clr_cnt;
    logic [XLEN-1:0]      r_pc;
    logic [REG_COUNT-1:0] r_rf_valid;
    logic                 r_s1_v;
    logic                 r_s2_v;
    logic                 r_wb_v;
    logic [1:0]           r_q_cnt;

    // payload
    t_instr          r_s1;
    logic            r_s1_v1, r_s1_v2, r_s1_vd;
    t_exec           r_s2;
    logic [RIDX_W-1:0] r_wb_rd;
    logic [XLEN-1:0] r_wb_val;
    t_result         r_q [2];

    logic            adv, accept, pop, push;
    logic            q_head_load;
    t_instr          in_item;
    logic [XLEN-1:0] rf_d1, rf_d2, rf_dd, dm_rdata;
    logic [XLEN-1:0] s2_val, op_a, op_b2, op_d, op_b;
    logic            s2_fwd;
    t_exec           n_s2;
    t_result         s2_res;
    logic [XLEN-1:0] ea, pc_base;
    logic            ea_ok;
    logic            rf_we;
    logic            dm_we;
    logic [MAW-1:0]  dm_waddr;
    logic [XLEN-1:0] dm_wdata;

    // whole pipe moves together; it holds only while the queue cannot take s2
    assign adv    = !(r_s2_v && r_q_cnt == 2'd2 && !o_result.ready);
    assign i_instr.ready = adv && !r_clr;
    assign accept = i_instr.valid && i_instr.ready;
    assign pop    = o_result.valid && o_result.ready;
    assign push   = adv && r_s2_v;

    // new result goes to the head when the queue is empty or its only item leaves
    assign q_head_load = push && (r_q_cnt == 2'd0 || (pop && r_q_cnt == 2'd1));

    assign in_item.action = i_instr.action;
    assign in_item.rd     = i_instr.dest_index;
    assign in_item.rs1    = i_instr.src1_index;
    assign in_item.rs2    = i_instr.src2_index;
    assign in_item.imm    = i_instr.immediate;
    assign in_item.jflag  = i_instr.is_jump_or_nop;

    // register file: three read copies, written alike
    assign rf_we = adv && r_s2_v && r_s2.wr;

    dseu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(r_s2.rd), .i_wdata(s2_val),
        .i_re(adv), .i_raddr(in_item.rs1), .o_rdata(rf_d1)
    );
    dseu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(r_s2.rd), .i_wdata(s2_val),
        .i_re(adv), .i_raddr(in_item.rs2), .o_rdata(rf_d2)
    );
    dseu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_d (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(r_s2.rd), .i_wdata(s2_val),
        .i_re(adv), .i_raddr(in_item.rd), .o_rdata(rf_dd)
    );

    // load data returns in s2; bad address loads zero
    always_comb begin
        if (r_s2.is_ld) begin
            s2_val = r_s2.ld_ok ? dm_rdata : '0;
        end else begin
            s2_val = r_s2.val;
        end
    end

    assign s2_fwd = r_s2_v && r_s2.wr;

    always_comb begin
        op_a  = fwd(r_s1.rs1, rf_d1, r_s1_v1, s2_fwd, r_s2.rd, s2_val,
                    r_wb_v, r_wb_rd, r_wb_val);
        op_b2 = fwd(r_s1.rs2, rf_d2, r_s1_v2, s2_fwd, r_s2.rd, s2_val,
                    r_wb_v, r_wb_rd, r_wb_val);
        op_d  = fwd(r_s1.rd, rf_dd, r_s1_vd, s2_fwd, r_s2.rd, s2_val,
                    r_wb_v, r_wb_rd, r_wb_val);
    end

    assign op_b  = (r_s1.action <= A_SLE) ? op_b2 : r_s1.imm;
    assign ea    = op_a + r_s1.imm;
    assign ea_ok = (ea[1:0] == 2'b00) && (ea[XLEN-1:2] < 30'(MEM_WORDS));

    // execute
    always_comb begin
        n_s2       = '0;
        n_s2.rd    = r_s1.rd;
        pc_base    = r_pc;
        unique case (r_s1.action) inside
            A_ADD, A_ADDI: begin
                n_s2.wr  = 1'b1;
                n_s2.val = op_a + op_b;
            end
            A_SUB, A_SUBI: begin
                n_s2.wr  = 1'b1;
                n_s2.val = op_a - op_b;
            end
            A_AND, A_ANDI: begin
                n_s2.wr  = 1'b1;
                n_s2.val = op_a & op_b;
            end
            A_OR, A_ORI: begin
                n_s2.wr  = 1'b1;
                n_s2.val = op_a | op_b;
            end
            A_XOR, A_XORI: begin
                n_s2.wr  = 1'b1;
                n_s2.val = op_a ^ op_b;
            end
            A_SEQ, A_SEQI: begin
                n_s2.wr  = 1'b1;
                n_s2.val = {{(XLEN-1){1'b0}}, (op_a == op_b)};
            end
            A_SLE, A_SLEI: begin
                n_s2.wr  = 1'b1;
                n_s2.val = {{(XLEN-1){1'b0}}, ($signed(op_a) <= $signed(op_b))};
            end
            A_LHI: begin
                n_s2.wr  = 1'b1;
                n_s2.val = {r_s1.imm[15:0], 16'h0000};
            end
            A_LW: begin
                n_s2.wr    = 1'b1;
                n_s2.is_ld = 1'b1;
                n_s2.ld_ok = ea_ok;
            end
            A_SW: begin
                n_s2.mw    = ea_ok;
                n_s2.saddr = ea_ok ? ea : '0;
            end
            A_BEQZ: begin
                if (op_a == '0) begin
                    pc_base = r_pc + r_s1.imm;
                end
            end
            A_BNEZ: begin
                if (op_a != '0) begin
                    pc_base = r_pc + r_s1.imm;
                end
            end
            A_JR: begin
                if (r_s1.jflag) begin
                    pc_base = op_a;
                end
            end
            default: begin
                // undefined codes act as a no-op
            end
        endcase
        if (!n_s2.wr) begin
            n_s2.rd = '0;
        end
        n_s2.pc = pc_base + 32'd4;
    end

    // data memory: sweep after reset, store or load from s1
    assign dm_we    = r_clr || (adv && r_s1_v && r_s1.action == A_SW && ea_ok);
    assign dm_waddr = r_clr ? r_clr_cnt : ea[MAW+1:2];
    assign dm_wdata = r_clr ? '0 : op_d;

    dseu_ram #(.WIDTH(XLEN), .DEPTH(MEM_WORDS)) u_dmem (
        .i_clk(i_clk), .i_we(dm_we), .i_waddr(dm_waddr), .i_wdata(dm_wdata),
        .i_re(adv), .i_raddr(ea[MAW+1:2]), .o_rdata(dm_rdata)
    );

    // result of s2 as it enters the queue
    always_comb begin
        s2_res.next_pc       = r_s2.pc;
        s2_res.reg_written   = r_s2.wr;
        s2_res.written_index = r_s2.rd;
        s2_res.written_value = r_s2.wr ? s2_val : '0;
        s2_res.mem_written   = r_s2.mw;
        s2_res.store_address = r_s2.saddr;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_cnt  <= '0;
            r_pc       <= '0;
            r_rf_valid <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_wb_v     <= 1'b0;
            r_q_cnt    <= 2'd0;
        end else begin
            if (r_clr) begin
                r_clr_cnt <= r_clr_cnt + MAW'(1);
                if (r_clr_cnt == MAW'(MEM_WORDS - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (adv) begin
                r_s1_v <= accept;
                r_s2_v <= r_s1_v;
                r_wb_v <= r_s2_v && r_s2.wr;
                if (r_s1_v) begin
                    r_pc <= n_s2.pc;
                end
                if (rf_we) begin
                    r_rf_valid[r_s2.rd] <= 1'b1;
                end
            end
            r_q_cnt <= r_q_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1     <= in_item;
            r_s1_v1  <= r_rf_valid[in_item.rs1];
            r_s1_v2  <= r_rf_valid[in_item.rs2];
            r_s1_vd  <= r_rf_valid[in_item.rd];
            r_s2     <= n_s2;
            r_wb_rd  <= r_s2.rd;
            r_wb_val <= s2_val;
        end
        if (q_head_load) begin
            r_q[0] <= s2_res;
        end else if (pop) begin
            r_q[0] <= r_q[1];
        end
        if (push && !q_head_load) begin
            r_q[1] <= s2_res;
        end
    end

    assign o_result.valid         = (r_q_cnt != 2'd0);
    assign o_result.next_pc       = r_q[0].next_pc;
    assign o_result.reg_written   = r_q[0].reg_written;
    assign o_result.written_index = r_q[0].written_index;
    assign o_result.written_value = r_q[0].written_value;
    assign o_result.mem_written   = r_q[0].mem_written;
    assign o_result.store_address = r_q[0].store_address;

endmodule

[sv/dseu_ram.sv]
module dseu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[tb/tb_dlx_subset_execute_unit.sv]
`timescale 1ns / 1ps

module tb_dlx_subset_execute_unit;
    import dseu_pkg::*;

    // run shape
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 1025;
    localparam int TAIL_CYCLES    = 16;
    // longest quiet stretch: reset, the memory clearing sweep, then idling
    localparam int WATCHDOG_LIMIT = 4 * (MEM_WORDS_DEF + RESET_CYCLES) + 400;
    localparam int PRINT_CAP      = 100;

    // mirror of the execute stage plus the queue of results still owed by the block
    class exec_checker;
        logic [XLEN-1:0] pc_now;
        logic [XLEN-1:0] regs [REG_COUNT];
        logic [XLEN-1:0] mem [MEM_WORDS_DEF];
        t_result         awaited[$];
        int              errors;
        int              seen;

        function new();
            pc_now = '0;
            foreach (regs[i]) regs[i] = '0;
            foreach (mem[i]) mem[i] = '0;
            errors = 0;
            seen   = 0;
        endfunction

        function bit addr_in_range(logic [XLEN-1:0] ea);
            return (ea[1:0] == 2'b00) && (ea[XLEN-1:2] < MEM_WORDS_DEF);
        endfunction

        // one instruction against the mirrored state, returns what the block reports
        function t_result exec_instr(t_instr it);
            logic [XLEN-1:0] a;
            logic [XLEN-1:0] b;
            logic [XLEN-1:0] val;
            logic [XLEN-1:0] ea;
            logic [XLEN-1:0] pc;
            logic            wr;
            t_result         r;
            a   = regs[it.rs1];
            b   = (it.action <= A_SLE) ? regs[it.rs2] : it.imm;
            ea  = a + it.imm;
            pc  = pc_now;
            wr  = 1'b0;
            val = '0;
            r   = '0;
            case (it.action)
                A_ADD, A_ADDI: begin val = a + b; wr = 1'b1; end
                A_SUB, A_SUBI: begin val = a - b; wr = 1'b1; end
                A_AND, A_ANDI: begin val = a & b; wr = 1'b1; end
                A_OR,  A_ORI:  begin val = a | b; wr = 1'b1; end
                A_XOR, A_XORI: begin val = a ^ b; wr = 1'b1; end
                A_SEQ, A_SEQI: begin val = {31'b0, a == b}; wr = 1'b1; end
                A_SLE, A_SLEI: begin val = {31'b0, $signed(a) <= $signed(b)}; wr = 1'b1; end
                A_LHI: begin
                    val = it.imm << 16;
                    wr  = 1'b1;
                end
                A_LW: begin
                    val = addr_in_range(ea) ? mem[ea[XLEN-1:2]] : '0;
                    wr  = 1'b1;
                end
                A_SW: begin
                    if (addr_in_range(ea)) begin
                        mem[ea[XLEN-1:2]] = regs[it.rd];
                        r.mem_written     = 1'b1;
                        r.store_address   = ea;
                    end
                end
                A_BEQZ: if (a == '0) pc = pc + it.imm;
                A_BNEZ: if (a != '0) pc = pc + it.imm;
                A_JR:   if (it.jflag) pc = a;
                default: ;
            endcase
            pc     = pc + 32'd4;
            pc_now = pc;
            if (wr) begin
                regs[it.rd]     = val;
                r.reg_written   = 1'b1;
                r.written_index = it.rd;
                r.written_value = val;
            end
            r.next_pc = pc;
            return r;
        endfunction

        function void note_instr(t_instr it);
            awaited.push_back(exec_instr(it));
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= PRINT_CAP) $display("mismatch: %s", msg);
        endtask

        task check_result(t_result got);
            t_result want;
            string   bad;
            seen++;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing awaited", seen));
                return;
            end
            want = awaited.pop_front();
            bad  = "";
            if (got.next_pc !== want.next_pc)
                bad = {bad, $sformatf(" next_pc %h want %h", got.next_pc, want.next_pc)};
            if (got.reg_written !== want.reg_written)
                bad = {bad, $sformatf(" reg_written %b want %b",
                                      got.reg_written, want.reg_written)};
            if (got.written_index !== want.written_index)
                bad = {bad, $sformatf(" written_index %0d want %0d",
                                      got.written_index, want.written_index)};
            if (got.written_value !== want.written_value)
                bad = {bad, $sformatf(" written_value %h want %h",
                                      got.written_value, want.written_value)};
            if (got.mem_written !== want.mem_written)
                bad = {bad, $sformatf(" mem_written %b want %b",
                                      got.mem_written, want.mem_written)};
            if (got.store_address !== want.store_address)
                bad = {bad, $sformatf(" store_address %h want %h",
                                      got.store_address, want.store_address)};
            if (bad != "") report_mismatch($sformatf("result %0d:%s", seen, bad));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    dseu_in_if  instr_if ();
    dseu_out_if result_if ();

    exec_checker board = new();

    int idle_cycles = 0;
    int send_calm   = 0;
    int sink_calm   = 0;

    dlx_subset_execute_unit #(
        .MEM_WORDS (MEM_WORDS_DEF)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_instr  (instr_if),
        .o_result (result_if)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // immediates lean toward the extremes and small values around zero
    function automatic logic [XLEN-1:0] rand_imm();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 32) - 16;
            default: return $urandom;
        endcase
    endfunction

    // byte addresses: mostly a small hot window so loads see earlier stores,
    // then the whole memory, misaligned, just past the end, anywhere
    function automatic logic [XLEN-1:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 4 * $urandom_range(0, 31);
        if (r < 80) return 4 * $urandom_range(0, MEM_WORDS_DEF - 1);
        if (r < 88) return 4 * $urandom_range(0, 31) + $urandom_range(1, 3);
        if (r < 95) return MEM_WORDS_DEF * 4 + 4 * $urandom_range(0, 15);
        return $urandom;
    endfunction

    function automatic t_instr instr_of(logic [ACT_W-1:0] act, int rd, int rs1, int rs2,
                                        logic [XLEN-1:0] imm, logic jflag);
        t_instr it;
        it        = '0;
        it.action = act;
        it.rd     = rd[RIDX_W-1:0];
        it.rs1    = rs1[RIDX_W-1:0];
        it.rs2    = rs2[RIDX_W-1:0];
        it.imm    = imm;
        it.jflag  = jflag;
        return it;
    endfunction

    // random instruction, built from the current mirrored state so that memory
    // operands land where they are meant to and compares can come out true
    function automatic t_instr make_random_instr();
        t_instr it;
        int     kind;
        int     start;
        it        = '0;
        it.rd     = RIDX_W'($urandom_range(0, 31));
        it.rs1    = RIDX_W'($urandom_range(0, 31));
        it.rs2    = RIDX_W'($urandom_range(0, 31));
        it.imm    = rand_imm();
        it.jflag  = 1'($urandom_range(0, 1));
        kind      = $urandom_range(0, 99);
        if (kind < 28) begin
            it.action = ACT_W'($urandom_range(A_ADD, A_SLE));
            // same register on both sides gives equal compares and zero results
            if ($urandom_range(0, 3) == 0) it.rs2 = it.rs1;
        end else if (kind < 48) begin
            it.action = ACT_W'($urandom_range(A_ADDI, A_SLEI));
            case ($urandom_range(0, 3))
                0: it.imm = board.regs[it.rs1];
                1: it.imm = board.regs[it.rs1] + $urandom_range(0, 2) - 1;
                default: ;
            endcase
        end else if (kind < 54) begin
            it.action = A_LHI;
        end else if (kind < 80) begin
            it.action = (kind < 68) ? A_SW : A_LW;
            it.imm    = pick_address() - board.regs[it.rs1];
        end else if (kind < 90) begin
            it.action = $urandom_range(0, 1) ? A_BEQZ : A_BNEZ;
            // half the time test a register that holds zero, if there is one
            if ($urandom_range(0, 1)) begin
                start = $urandom_range(0, 31);
                for (int k = 0; k < REG_COUNT; k++) begin
                    if (board.regs[(start + k) % REG_COUNT] == '0) begin
                        it.rs1 = RIDX_W'((start + k) % REG_COUNT);
                        break;
                    end
                end
            end
            if ($urandom_range(0, 1)) it.imm = 4 * ($urandom_range(0, 64) - 32);
        end else if (kind < 95) begin
            it.action = A_JR;
        end else begin
            // undefined codes behave as the no-op
            it.action = ACT_W'($urandom_range(20, 31));
        end
        return it;
    endfunction

    // present one item, hold it until taken, then hand it to the mirror
    task automatic send_instr(input t_instr it, input int gap);
        if (gap > 0) begin
            instr_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        instr_if.valid          <= 1'b1;
        instr_if.action         <= it.action;
        instr_if.dest_index     <= it.rd;
        instr_if.src1_index     <= it.rs1;
        instr_if.src2_index     <= it.rs2;
        instr_if.immediate      <= it.imm;
        instr_if.is_jump_or_nop <= it.jflag;
        do @(posedge i_clk); while (instr_if.ready !== 1'b1);
        board.note_instr(it);
    endtask

    task automatic send_next(input t_instr it);
        int gap;
        if (send_calm > 0) begin
            gap = 0;
            send_calm--;
        end else begin
            gap = pick_gap();
            // every so often a run of back-to-back items
            if ($urandom_range(0, 99) == 0) send_calm = $urandom_range(30, 60);
        end
        send_instr(it, gap);
    endtask

    // stimulus and end of run
    initial begin : stimulus
        t_instr directed[$];
        i_rst_n                 = 1'b0;
        instr_if.valid          = 1'b0;
        instr_if.action         = A_ADD;
        instr_if.dest_index     = '0;
        instr_if.src1_index     = '0;
        instr_if.src2_index     = '0;
        instr_if.immediate      = '0;
        instr_if.is_jump_or_nop = 1'b0;

        // largest and smallest values, then every register-register operation
        directed.push_back(instr_of(A_ADDI, 1, 0, 0, 32'h7FFF_FFFF, 1'b0));
        directed.push_back(instr_of(A_ADDI, 2, 0, 0, 32'h8000_0000, 1'b0));
        directed.push_back(instr_of(A_ADD, 3, 1, 2, '0, 1'b0));
        // jump flag set on an operation that is not a jump
        directed.push_back(instr_of(A_SUB, 5, 2, 1, '0, 1'b1));
        directed.push_back(instr_of(A_AND, 6, 3, 1, '0, 1'b0));
        directed.push_back(instr_of(A_OR, 7, 1, 2, '0, 1'b0));
        directed.push_back(instr_of(A_XOR, 8, 3, 1, '0, 1'b0));
        directed.push_back(instr_of(A_SEQ, 9, 1, 1, '0, 1'b0));
        directed.push_back(instr_of(A_SLE, 10, 2, 1, '0, 1'b0));
        // immediate forms
        directed.push_back(instr_of(A_SUBI, 12, 2, 0, 32'd1, 1'b0));
        directed.push_back(instr_of(A_ANDI, 13, 3, 0, 32'h0F0F_0F0F, 1'b0));
        directed.push_back(instr_of(A_ORI, 14, 0, 0, 32'h0000_0100, 1'b0));
        directed.push_back(instr_of(A_XORI, 15, 3, 0, 32'hFFFF_FFFF, 1'b0));
        directed.push_back(instr_of(A_SEQI, 16, 14, 0, 32'h0000_0100, 1'b0));
        directed.push_back(instr_of(A_SLEI, 17, 1, 0, 32'h8000_0000, 1'b0));
        // r0 is a plain register and takes the write
        directed.push_back(instr_of(A_LHI, 0, 0, 0, 32'hFFFF_FFFF, 1'b0));
        // store then load back, misaligned store, load just past the end
        directed.push_back(instr_of(A_SW, 1, 14, 0, '0, 1'b0));
        directed.push_back(instr_of(A_LW, 19, 14, 0, '0, 1'b0));
        directed.push_back(instr_of(A_SW, 1, 14, 0, 32'd2, 1'b0));
        directed.push_back(instr_of(A_LW, 20, 14, 0, MEM_WORDS_DEF * 4 - 32'h100, 1'b0));
        // taken branches both ways, jump, no-op, undefined code
        directed.push_back(instr_of(A_BEQZ, 0, 22, 0, 32'h0000_0040, 1'b0));
        directed.push_back(instr_of(A_BNEZ, 0, 1, 0, -32'sd8, 1'b0));
        directed.push_back(instr_of(A_JR, 0, 14, 0, '0, 1'b1));
        directed.push_back(instr_of(A_JR, 0, 14, 0, '0, 1'b0));
        directed.push_back(instr_of(5'd31, 0, 1, 0, '0, 1'b1));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // input ready stays low through the clearing sweep, the handshake waits it out
        foreach (directed[i]) send_next(directed[i]);
        repeat (RANDOM_ITEMS) send_next(make_random_instr());
        instr_if.valid <= 1'b0;

        // drain, then idle through a short tail for any stray result
        while (board.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // result side back-pressure: random stalls with calm stretches
    initial begin : result_sink
        int n;
        result_if.ready = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        forever begin
            if (sink_calm > 0) begin
                n = 0;
                sink_calm--;
            end else begin
                n = pick_gap();
                if ($urandom_range(0, 49) == 0) sink_calm = $urandom_range(10, 30);
            end
            if (n > 0) begin
                result_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            result_if.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // result check and watchdog, sampled at the clock edge
    always @(posedge i_clk) begin : monitor
        t_result got;
        bit      took_item;
        bit      took_result;
        took_item   = (instr_if.valid === 1'b1) && (instr_if.ready === 1'b1);
        took_result = (result_if.valid === 1'b1) && (result_if.ready === 1'b1);
        if (i_rst_n === 1'b1 && took_result) begin
            got.next_pc       = result_if.next_pc;
            got.reg_written   = result_if.reg_written;
            got.written_index = result_if.written_index;
            got.written_value = result_if.written_value;
            got.mem_written   = result_if.mem_written;
            got.store_address = result_if.store_address;
            board.check_result(got);
        end
        // quiet cycles count up until something moves on either side
        if (took_item || took_result) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule
